/* src/idp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ISO date parser.
// No dependencies; imported by idp_char_parser, idp_day_calc and the top level.
package idp_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FORMAT    = 2'd1;
   localparam logic [1:0] STATUS_BAD_MONTH = 2'd2;
   localparam logic [1:0] STATUS_BAD_DAY   = 2'd3;

   // character codes
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // character positions within YYYY-MM-DD
   localparam logic [3:0] POS_YEAR_HI0 = 4'd0;
   localparam logic [3:0] POS_YEAR_HI1 = 4'd1;
   localparam logic [3:0] POS_YEAR_LO0 = 4'd2;
   localparam logic [3:0] POS_YEAR_LO1 = 4'd3;
   localparam logic [3:0] POS_DASH_A   = 4'd4;
   localparam logic [3:0] POS_MONTH0   = 4'd5;
   localparam logic [3:0] POS_MONTH1   = 4'd6;
   localparam logic [3:0] POS_DASH_B   = 4'd7;
   localparam logic [3:0] POS_DAY1     = 4'd9;
   localparam logic [3:0] POS_LIMIT    = 4'd10;
   localparam logic [3:0] POS_SAT      = 4'd15;

   // fields of one parsed date, handed from the parser to the day calculator
   typedef struct packed {
      logic [13:0] year;      // full accumulated year
      logic [6:0]  year_hi;   // first two year digits
      logic [6:0]  year_lo;   // last two year digits
      logic [6:0]  month;
      logic [6:0]  day;
      logic        format_ok; // ten characters, all in the right form
   } snap_type;

endpackage

/* src/idp_char_parser.sv */
`timescale 1ns / 1ps
// Character stage: checks the YYYY-MM-DD format and accumulates the fields.
// Depends on idp_pkg; feeds a snapshot register read by idp_day_calc.
module idp_char_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_char_code,
   input  logic              req_last_char,
   output logic              snap_valid,
   input  logic              snap_ready,
   output idp_pkg::snap_type snap
);
   import idp_pkg::*;

   logic [3:0]  pos_ff, pos_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  year_hi_ff, year_hi_in;
   logic [6:0]  year_lo_ff, year_lo_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic        bad_ff, bad_in;
   logic        snap_valid_ff, snap_valid_in;
   snap_type    snap_ff, snap_in;

   logic        accept;
   logic        is_digit;
   logic [3:0]  digit;
   logic        bad_now;

   assign req_ready  = !snap_valid_ff || snap_ready;
   assign accept     = req_valid && req_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   assign is_digit = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign digit    = 4'(req_char_code - CHAR_ZERO);

   // format check and field accumulation for the current character
   always_comb begin
      year_in    = year_ff;
      year_hi_in = year_hi_ff;
      year_lo_in = year_lo_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      bad_now    = 1'b0;
      if (pos_ff >= POS_LIMIT) begin
         bad_now = 1'b1;
      end else if (pos_ff == POS_DASH_A || pos_ff == POS_DASH_B) begin
         bad_now = (req_char_code != CHAR_DASH);
      end else if (!is_digit) begin
         bad_now = 1'b1;
      end else begin
         case (pos_ff)
            POS_YEAR_HI0, POS_YEAR_HI1: begin
               year_in    = 14'(year_ff * 14'd10 + 14'(digit));
               year_hi_in = 7'(year_hi_ff * 7'd10 + 7'(digit));
            end
            POS_YEAR_LO0, POS_YEAR_LO1: begin
               year_in    = 14'(year_ff * 14'd10 + 14'(digit));
               year_lo_in = 7'(year_lo_ff * 7'd10 + 7'(digit));
            end
            POS_MONTH0, POS_MONTH1: month_in = 7'(month_ff * 7'd10 + 7'(digit));
            default:                day_in   = 7'(day_ff * 7'd10 + 7'(digit));
         endcase
      end
      bad_in = bad_ff || bad_now;
      pos_in = (pos_ff == POS_SAT) ? pos_ff : 4'(pos_ff + 4'd1);

      // snapshot of the finished string
      snap_in.year      = year_in;
      snap_in.year_hi   = year_hi_in;
      snap_in.year_lo   = year_lo_in;
      snap_in.month     = month_in;
      snap_in.day       = day_in;
      snap_in.format_ok = !bad_in && (pos_ff == POS_DAY1);

      snap_valid_in = snap_valid_ff;
      if (snap_ready) begin
         snap_valid_in = 1'b0;
      end
      if (accept && req_last_char) begin
         snap_valid_in = 1'b1;
      end
   end

   // accumulator state; cleared after the last character of a string
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         year_ff       <= '0;
         year_hi_ff    <= '0;
         year_lo_ff    <= '0;
         month_ff      <= '0;
         day_ff        <= '0;
         bad_ff        <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (accept) begin
            if (req_last_char) begin
               pos_ff     <= '0;
               year_ff    <= '0;
               year_hi_ff <= '0;
               year_lo_ff <= '0;
               month_ff   <= '0;
               day_ff     <= '0;
               bad_ff     <= 1'b0;
            end else begin
               pos_ff     <= pos_in;
               year_ff    <= year_in;
               year_hi_ff <= year_hi_in;
               year_lo_ff <= year_lo_in;
               month_ff   <= month_in;
               day_ff     <= day_in;
               bad_ff     <= bad_in;
            end
         end
      end
   end

   // snapshot payload
   always_ff @(posedge clock) begin
      if (accept && req_last_char) begin
         snap_ff <= snap_in;
      end
   end

endmodule

/* src/idp_day_calc.sv */
`timescale 1ns / 1ps
// Result stage: range checks and proleptic Gregorian day number.
// Depends on idp_pkg; takes the snapshot from idp_char_parser.
module idp_day_calc (
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_valid,
   output logic              snap_ready,
   input  idp_pkg::snap_type snap,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [13:0]       rsp_year_value,
   output logic [6:0]        rsp_month_value,
   output logic [6:0]        rsp_day_value,
   output logic [21:0]       rsp_day_number
);
   import idp_pkg::*;

   // days in a month, February given separately for leap years
   function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // days before the first of month m in a common year
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic [13:0] year_ff;
   logic [6:0]  month_ff, day_ff;
   logic [21:0] dnum_ff, dnum_in;

   logic        lo_nz;
   logic        leap;
   logic [3:0]  m4;
   logic        month_ok;
   logic        day_ok;
   logic [21:0] leaps;
   logic        load;

   assign snap_ready = !rsp_valid_ff || rsp_ready;
   assign load       = snap_valid && snap_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_year_value  = year_ff;
   assign rsp_month_value = month_ff;
   assign rsp_day_value   = day_ff;
   assign rsp_day_number  = dnum_ff;

   // leap rule on the two-digit halves: century years follow the upper half
   assign lo_nz    = |snap.year_lo;
   assign leap     = lo_nz ? (snap.year_lo[1:0] == 2'd0) : (snap.year_hi[1:0] == 2'd0);
   assign m4       = snap.month[3:0];
   assign month_ok = (snap.month >= 7'd1) && (snap.month <= 7'd12);
   assign day_ok   = (snap.day >= 7'd1) && (snap.day <= 7'(month_length(m4, leap)));

   // leap years in 0 .. year-1 = ceil(y/4) - ceil(y/100) + ceil(y/400)
   assign leaps = 22'(snap.year_hi) * 22'd24
                + 22'(7'(snap.year_lo + 7'd3) >> 2)
                + 22'(snap.year_hi >> 2)
                + 22'(snap.year_hi[1:0] != 2'd0 && !lo_nz);

   always_comb begin
      dnum_in = '0;
      if (!snap.format_ok) begin
         status_in = STATUS_FORMAT;
      end else if (!month_ok) begin
         status_in = STATUS_BAD_MONTH;
      end else if (!day_ok) begin
         status_in = STATUS_BAD_DAY;
      end else begin
         status_in = STATUS_OK;
         dnum_in   = 22'(snap.year) * 22'd365 + leaps
                   + 22'(days_before(m4))
                   + 22'(leap && (m4 > 4'd2))
                   + 22'(snap.day);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         year_ff   <= snap.year;
         month_ff  <= snap.month;
         day_ff    <= snap.day;
         dnum_ff   <= dnum_in;
      end
   end

endmodule

/* src/iso_date_parse_to_day_number_top.sv */
`timescale 1ns / 1ps
// ISO 8601 date parser: one character per request, one result per date string.
// Throughput: one character per cycle while req_ready is high, set by the accumulators.
// The edge that accepts the last character loads the snapshot register, and the result
// register loads from it once snap_ready is high; rsp_valid is raised with that load.
// Reset (synchronous, active high) clears position, accumulators and valid flags.
module iso_date_parse_to_day_number_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [13:0] rsp_year_value,
   output logic [6:0]  rsp_month_value,
   output logic [6:0]  rsp_day_value,
   output logic [21:0] rsp_day_number
);
   import idp_pkg::*;

   logic     snap_valid;
   logic     snap_ready;
   snap_type snap;

   // character parsing and accumulation
   idp_char_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap          (snap)
   );

   // range checks and day number
   idp_day_calc u_calc (
      .clock           (clock),
      .reset           (reset),
      .snap_valid      (snap_valid),
      .snap_ready      (snap_ready),
      .snap            (snap),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_year_value  (rsp_year_value),
      .rsp_month_value (rsp_month_value),
      .rsp_day_value   (rsp_day_value),
      .rsp_day_number  (rsp_day_number)
   );

endmodule
